// File: hdl/itrd_pkg.sv
// shared types, constants and helpers for the integer to radix digit converter
package itrd_pkg;

    // input width and derived sizes
    localparam int VALUE_BITS     = 31;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_TOTAL_W  = 5;

    localparam int STEP_BITS      = 8;
    localparam int DIV_CYCLES     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_BITS      = DIV_CYCLES * STEP_BITS;
    localparam int STEP_CNT_W     = $clog2(DIV_CYCLES + 1);

    localparam int STACK_DEPTH    = VALUE_BITS;
    localparam int IDX_W          = $clog2(STACK_DEPTH);
    localparam int CNT_W          = $clog2(STACK_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(65);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } itrd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic emit;
    } itrd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic quot_zero;
        logic rd_zero;
    } itrd_status_t;

    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
        end
        return c;
    endfunction

endpackage

// File: hdl/itrd_ctrl.sv
// sequencing state machine for the digit converter
module itrd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  itrd_pkg::itrd_status_t status,
    output itrd_pkg::itrd_cmd_t  cmd,
    output logic                 busy
);
    import itrd_pkg::*;

    itrd_state_t           state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  step_last;

    assign step_last = (step_reg == STEP_CNT_W'(DIV_CYCLES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_last)
                begin
                    step_next = '0;
                    if (status.quot_zero)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (status.rd_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cmd.push = step_last;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hdl/itrd_dp.sv
// datapath: radix register, multi-cycle divider, digit stack and output registers
module itrd_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  itrd_pkg::itrd_cmd_t              cmd,
    output itrd_pkg::itrd_status_t           status,
    input  logic [itrd_pkg::VALUE_BITS-1:0]  value,
    input  logic                             radix_we,
    input  logic [itrd_pkg::RADIX_W-1:0]     radix_wdata,
    output logic                             digit_valid,
    output logic [itrd_pkg::DIGIT_W-1:0]     digit_value,
    output logic [itrd_pkg::CHAR_W-1:0]      digit_char,
    output logic [itrd_pkg::DIGIT_TOTAL_W-1:0] digit_total,
    output logic                             last_digit
);
    import itrd_pkg::*;

    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   divisor_reg;
    logic [WORK_BITS-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     rd_reg;
    logic [DIGIT_W-1:0]   stack_reg [STACK_DEPTH];

    logic                 valid_reg;
    logic [DIGIT_W-1:0]   dval_reg;
    logic [CHAR_W-1:0]    dchar_reg;
    logic [DIGIT_TOTAL_W-1:0] dtotal_reg;
    logic                 dlast_reg;

    // radix register, out-of-range writes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_we && radix_wdata >= RADIX_MIN && radix_wdata <= RADIX_MAX)
        begin
            radix_reg <= radix_wdata;
        end
    end

    // eight restoring division steps per cycle, dividend msb first
    always_comb
    begin
        logic [RADIX_W-1:0]   r;
        logic [DIGIT_W-1:0]   rem;
        logic [STEP_BITS-1:0] qbits;
        rem   = rem_reg;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            r = {rem, work_reg[WORK_BITS-1-i]};
            if (r >= divisor_reg)
            begin
                r            = r - divisor_reg;
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            rem = r[DIGIT_W-1:0];
        end
        rem_next  = rem;
        work_next = WORK_BITS'(work_reg << STEP_BITS) | WORK_BITS'(qbits);
    end

    assign status.quot_zero = (work_next == '0);
    assign status.rd_zero   = (rd_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg    <= WORK_BITS'(value);
            rem_reg     <= '0;
            cnt_reg     <= '0;
            divisor_reg <= radix_reg;
        end
        else if (cmd.step)
        begin
            work_reg <= work_next;
            if (cmd.push)
            begin
                stack_reg[cnt_reg[IDX_W-1:0]] <= rem_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                rd_reg  <= cnt_reg[IDX_W-1:0];
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
        else if (cmd.emit)
        begin
            rd_reg <= rd_reg - IDX_W'(1);
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dval_reg   <= stack_reg[rd_reg];
            dchar_reg  <= char_of(stack_reg[rd_reg]);
            dtotal_reg <= DIGIT_TOTAL_W'(cnt_reg);
            dlast_reg  <= (rd_reg == '0);
        end
    end

    assign digit_valid = valid_reg;
    assign digit_value = dval_reg;
    assign digit_char  = dchar_reg;
    assign digit_total = dtotal_reg;
    assign last_digit  = dlast_reg;

endmodule

// File: hdl/integer_to_radix_digits_unit.sv
// top level of the integer to radix digit converter
//
// converts one unsigned value per transfer into digits of the radix held in
// the radix register (2 to 16, reset 10; writes outside that range are dropped)
// and sends them out most significant first, one digit per cycle on
// consecutive cycles, each marked by digit_valid for a single cycle. the
// receiver cannot stall, so it must take every digit as it appears. a value
// of zero gives one digit 0. the divider retires eight dividend bits per cycle
// and runs over the whole dividend for each digit, pushing the remainder onto
// the digit stack (up to 31 digits, for radix 2); the stack is then played
// back, and busy stays high from the first division step until the last digit
// has been read from the stack. start is taken on a cycle where busy is low;
// the radix should only be written while busy is low and no digits are still coming out.
module integer_to_radix_digits_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [itrd_pkg::VALUE_BITS-1:0]    value,
    input  logic                               radix_we,
    input  logic [itrd_pkg::RADIX_W-1:0]       radix_wdata,
    output logic                               digit_valid,
    output logic [itrd_pkg::DIGIT_W-1:0]       digit_value,
    output logic [itrd_pkg::CHAR_W-1:0]        digit_char,
    output logic [itrd_pkg::DIGIT_TOTAL_W-1:0] digit_total,
    output logic                               last_digit
);
    import itrd_pkg::*;

    itrd_cmd_t    cmd;
    itrd_status_t status;

    // sequencing: idle, divide per digit, emit from stack
    itrd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // radix register, divider, digit stack, result registers
    itrd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .digit_valid (digit_valid),
        .digit_value (digit_value),
        .digit_char  (digit_char),
        .digit_total (digit_total),
        .last_digit  (last_digit)
    );

endmodule

// File: hdl/itrd_checker.sv
// port-level checks for the digit converter, bound to the top level
module itrd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               digit_valid,
    input logic [itrd_pkg::DIGIT_W-1:0]       digit_value,
    input logic [itrd_pkg::CHAR_W-1:0]        digit_char,
    input logic [itrd_pkg::DIGIT_TOTAL_W-1:0] digit_total,
    input logic                               last_digit
);
    import itrd_pkg::*;

    // an accepted transfer makes the unit busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted start");

    // character matches digit value
    a_char_match: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |->
            ((digit_value < DEC_LIMIT) && (digit_char == CHAR_ZERO + CHAR_W'(digit_value))) ||
            ((digit_value >= DEC_LIMIT) &&
             (digit_char == CHAR_A + CHAR_W'(digit_value - DEC_LIMIT))))
        else $error("digit_char does not match digit_value");

    // digits of one run come back to back with a steady count
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && !last_digit) |=> (digit_valid && digit_total == $past(digit_total)))
        else $error("digit run broken or count changed");

    // a run ends before anything else appears
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && last_digit) |=> !digit_valid)
        else $error("digit right after end of run");

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (digit_total != '0))
        else $error("zero digit count");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .digit_valid (digit_valid),
    .digit_value (digit_value),
    .digit_char  (digit_char),
    .digit_total (digit_total),
    .last_digit  (last_digit)
);
